// ===== design/hc2_pkg.sv =====
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher core.
// No dependencies; imported by every module of the block.
package hc2_pkg;

    localparam int unsigned LetterW = 5;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [LetterW-1:0] Letters = 5'd26;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_KEY_R0C0  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_R0C1  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_R1C0  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_R1C1  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 3'd4;

    // Reset values of the key registers
    localparam logic [LetterW-1:0] KeyR0C0Rst = 5'd2;
    localparam logic [LetterW-1:0] KeyR0C1Rst = 5'd3;
    localparam logic [LetterW-1:0] KeyR1C0Rst = 5'd3;
    localparam logic [LetterW-1:0] KeyR1C1Rst = 5'd6;

    localparam logic DirEncrypt = 1'b0;
    localparam logic DirDecrypt = 1'b1;

    typedef logic [LetterW-1:0] letter_t;

    typedef struct packed {
        letter_t p;   // first letter of the pair
        letter_t x;   // second letter of the pair
    } pair_t;

    typedef struct packed {
        letter_t r0c0;
        letter_t r0c1;
        letter_t r1c0;
        letter_t r1c1;
        logic    direction;
    } key_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DET,
        BK_INV,
        BK_MPROD,
        BK_MRED,
        BK_YPROD,
        BK_YRED,
        BK_EMIT0,
        BK_EMIT1
    } back_state_t;

    // Fold a 5-bit value into 0..25.
    function automatic letter_t reduce5(input letter_t v);
        letter_t r;
        r = v;
        if (v >= Letters)
        begin
            r = v - Letters;
        end
        return r;
    endfunction

    // v mod 26 for v < 2048: quotient estimate by 78/2048 (never high, at
    // most one low), then one correcting subtract.
    function automatic letter_t mod26(input logic [10:0] v);
        logic [17:0] qprod;
        logic [6:0]  q;
        logic [10:0] qm;
        logic [10:0] r;
        qprod = 18'(v) * 18'd78;
        q     = qprod[17:11];
        qm    = 11'(q) * 11'd26;
        r     = v - qm;
        if (r >= 11'd26)
        begin
            r = r - 11'd26;
        end
        return r[LetterW-1:0];
    endfunction

    // Multiplicative inverse mod 26, zero where none exists.
    function automatic letter_t inv26(input letter_t d);
        letter_t r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/hc2_front.sv =====
// Front end: accepts letters, folds them into 0..25 and pairs them.
// Depends on hc2_pkg; pushes completed pairs into hc2_pairq.
module hc2_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            letter_valid,
    input  hc2_pkg::letter_t letter_in,
    output logic            letter_stall,
    input  logic            q_full,
    output logic            push,
    output hc2_pkg::pair_t  push_pair
);
    import hc2_pkg::*;

    letter_t held_letter_reg;
    letter_t held_letter_next;
    logic    held_valid_reg;
    logic    held_valid_next;
    letter_t letter_fold;
    logic    accept;

    assign letter_fold  = reduce5(letter_in);
    // Only the second letter of a pair needs queue room.
    assign letter_stall = held_valid_reg && q_full;
    assign accept       = letter_valid && !letter_stall;
    assign push         = accept && held_valid_reg;
    assign push_pair    = '{p: held_letter_reg, x: letter_fold};

    always_comb
    begin
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        if (accept)
        begin
            held_valid_next = !held_valid_reg;
            if (!held_valid_reg)
            begin
                held_letter_next = letter_fold;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
        end
    end

endmodule

// ===== design/hc2_pairq.sv =====
// Two-entry queue of letter pairs between the front and back ends.
// Depends on hc2_pkg for pair_t.
module hc2_pairq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hc2_pkg::pair_t push_pair,
    input  logic           pop,
    output hc2_pkg::pair_t head,
    output logic           empty,
    output logic           full
);
    import hc2_pkg::*;

    pair_t       mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/hc2_back.sv =====
// Back end: takes a pair from the queue, forms the (inverse) key matrix,
// multiplies mod 26 and emits two results through an output register.
// Depends on hc2_pkg.
module hc2_back (
    input  logic             clk,
    input  logic             rst_n,
    input  hc2_pkg::key_t    key,
    input  hc2_pkg::pair_t   head,
    input  logic             q_empty,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output hc2_pkg::letter_t letter_out,
    output logic             pair_end,
    output logic             key_error
);
    import hc2_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    pair_t       pair_reg;
    logic [10:0] det_raw_reg;
    letter_t     inv_reg;
    logic        err_reg;
    logic [9:0]  mprod_reg [4];
    letter_t     m_reg [4];
    logic [10:0] y0_raw_reg;
    logic [10:0] y1_raw_reg;
    letter_t     y0_reg;
    letter_t     y1_reg;

    logic        result_valid_reg;
    logic        result_valid_next;
    letter_t     letter_out_reg;
    logic        pair_end_reg;
    logic        key_error_reg;

    logic        load0;
    logic        load1;
    logic        slot_free;

    letter_t     ka;
    letter_t     kb;
    letter_t     kc;
    letter_t     kd;
    letter_t     det;
    letter_t     inv;
    logic [9:0]  ad;
    logic [9:0]  bc;
    logic [9:0]  m00p;
    logic [9:0]  m01x;
    logic [9:0]  m10p;
    logic [9:0]  m11x;

    assign ka = reduce5(key.r0c0);
    assign kb = reduce5(key.r0c1);
    assign kc = reduce5(key.r1c0);
    assign kd = reduce5(key.r1c1);

    assign ad  = 10'(ka) * 10'(kd);
    assign bc  = 10'(kb) * 10'(kc);
    assign det = mod26(det_raw_reg);
    assign inv = inv26(det);

    assign m00p = 10'(m_reg[0]) * 10'(pair_reg.p);
    assign m01x = 10'(m_reg[1]) * 10'(pair_reg.x);
    assign m10p = 10'(m_reg[2]) * 10'(pair_reg.p);
    assign m11x = 10'(m_reg[3]) * 10'(pair_reg.x);

    assign slot_free    = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign letter_out   = letter_out_reg;
    assign pair_end     = pair_end_reg;
    assign key_error    = key_error_reg;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load0      = 1'b0;
        load1      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_DET;
                end
            end
            BK_DET:   state_next = BK_INV;
            BK_INV:   state_next = BK_MPROD;
            BK_MPROD: state_next = BK_MRED;
            BK_MRED:  state_next = BK_YPROD;
            BK_YPROD: state_next = BK_YRED;
            BK_YRED:  state_next = BK_EMIT0;
            BK_EMIT0:
            begin
                if (slot_free)
                begin
                    load0      = 1'b1;
                    state_next = BK_EMIT1;
                end
            end
            BK_EMIT1:
            begin
                if (slot_free)
                begin
                    load1      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load0 || load1)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath: one product or one reduction per step.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pair_reg <= head;
        end
        if (state_reg == BK_DET)
        begin
            // ad - bc kept non-negative by adding 26*26
            det_raw_reg <= 11'(ad) + 11'd676 - 11'(bc);
        end
        if (state_reg == BK_INV)
        begin
            inv_reg <= inv;
            err_reg <= (key.direction == DirDecrypt) && (inv == 5'd0);
        end
        if (state_reg == BK_MPROD)
        begin
            if (key.direction == DirDecrypt)
            begin
                mprod_reg[0] <= 10'(kd) * 10'(inv_reg);
                mprod_reg[1] <= 10'(Letters - kb) * 10'(inv_reg);
                mprod_reg[2] <= 10'(Letters - kc) * 10'(inv_reg);
                mprod_reg[3] <= 10'(ka) * 10'(inv_reg);
            end
            else
            begin
                mprod_reg[0] <= 10'(ka);
                mprod_reg[1] <= 10'(kb);
                mprod_reg[2] <= 10'(kc);
                mprod_reg[3] <= 10'(kd);
            end
        end
        if (state_reg == BK_MRED)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m_reg[i] <= mod26(11'(mprod_reg[i]));
            end
        end
        if (state_reg == BK_YPROD)
        begin
            y0_raw_reg <= 11'(m00p) + 11'(m01x);
            y1_raw_reg <= 11'(m10p) + 11'(m11x);
        end
        if (state_reg == BK_YRED)
        begin
            y0_reg <= err_reg ? 5'd0 : mod26(y0_raw_reg);
            y1_reg <= err_reg ? 5'd0 : mod26(y1_raw_reg);
        end
        if (load0)
        begin
            letter_out_reg <= y0_reg;
            pair_end_reg   <= 1'b0;
            key_error_reg  <= err_reg;
        end
        else if (load1)
        begin
            letter_out_reg <= y1_reg;
            pair_end_reg   <= 1'b1;
            key_error_reg  <= err_reg;
        end
    end

endmodule

// ===== design/hill_cipher_2x2_mod26_core.sv =====
// Hill cipher 2x2 mod 26 core: letters in, enciphered or deciphered pairs out.
// Letters 0..25 (inputs 26..31 fold to 0..5) enter on the letter channel and
// are paired; each completed pair produces two results, first then second
// letter, the second marked by pair_end. The front end takes a letter each
// cycle while the two-entry pair queue has room; the back end handles one
// pair at a time (determinant, inverse lookup, matrix products and
// reductions, two output transactions) and returns to idle before popping
// the next, so the multi-step back end sets the sustained rate. In decrypt
// mode a key whose determinant has no inverse mod 26 yields key_error = 1 and
// letter 0 on both results. Key and direction registers are written through
// the cfg port, which is always ready; write them only while the block is idle.
// Depends on hc2_pkg, hc2_front, hc2_pairq and hc2_back.
module hill_cipher_2x2_mod26_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            letter_valid,
    output logic                            letter_stall,
    input  hc2_pkg::letter_t                letter_in,
    output logic                            result_valid,
    input  logic                            result_stall,
    output hc2_pkg::letter_t                letter_out,
    output logic                            pair_end,
    output logic                            key_error,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hc2_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [hc2_pkg::LetterW-1:0]     cfg_data
);
    import hc2_pkg::*;

    key_t  key_reg;
    key_t  key_next;
    logic  push;
    pair_t push_pair;
    logic  pop;
    pair_t head;
    logic  q_empty;
    logic  q_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_R0C0:  key_next.r0c0      = cfg_data;
                CFG_KEY_R0C1:  key_next.r0c1      = cfg_data;
                CFG_KEY_R1C0:  key_next.r1c0      = cfg_data;
                CFG_KEY_R1C1:  key_next.r1c1      = cfg_data;
                CFG_DIRECTION: key_next.direction = cfg_data[0];
                default:       key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '{r0c0: KeyR0C0Rst, r0c1: KeyR0C1Rst, r1c0: KeyR1C0Rst,
                         r1c1: KeyR1C1Rst, direction: DirEncrypt};
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    hc2_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_in    (letter_in),
        .letter_stall (letter_stall),
        .q_full       (q_full),
        .push         (push),
        .push_pair    (push_pair)
    );

    hc2_pairq u_pairq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pair (push_pair),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    hc2_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key_reg),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .letter_out   (letter_out),
        .pair_end     (pair_end),
        .key_error    (key_error)
    );

endmodule

// ===== bench/hill_cipher_2x2_mod26_core_tb.sv =====
// Self-checking testbench for the 2x2 Hill cipher mod-26 core.
// Feeds letter streams under several key/direction settings, predicts each pair in the
// bench, and compares every result transaction. Depends on hc2_pkg and the core.
module hill_cipher_2x2_mod26_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hc2_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct {
        letter_t letter_out;
        logic    pair_end;
        logic    key_error;
    } cipher_out_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 letter_valid = 1'b0;
    logic                 letter_stall;
    letter_t              letter_in    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    letter_t              letter_out;
    logic                 pair_end;
    logic                 key_error;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index    = '0;
    letter_t              cfg_data     = '0;

    // Letters waiting for the driver, and cipher results waiting for the block
    letter_t      letter_queue[$];
    cipher_out_t  expected_letters[$];

    // Bench copy of the key registers and the open pair
    letter_t      key_copy[4];
    logic         dir_copy;
    letter_t      held_copy;
    logic         held_copy_valid;

    int           send_gap;
    int           hold_left;
    int           stall_draw;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           letters_pushed;
    int           letters_accepted;
    int           results_checked;
    int           singular_pairs;
    int           error_count;
    int           cycle_count;
    int           dir_pos;

    letter_t directed_letters[24] = '{
        5'd0,  5'd25, 5'd26, 5'd31, 5'd13, 5'd7,
        5'd25, 5'd0,  5'd31, 5'd26, 5'd5,
        5'd9,  5'd0,  5'd25,
        5'd3,  5'd17, 5'd25, 5'd25,
        5'd3,  5'd17, 5'd12,
        5'd8,  5'd25, 5'd25
    };

    hill_cipher_2x2_mod26_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter_in    (letter_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .letter_out   (letter_out),
        .pair_end     (pair_end),
        .key_error    (key_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // No idle unless drawn at pct percent; then short gaps with an occasional long one
    function automatic int idle_length(input int pct);
        if ($urandom_range(99) >= pct)
        begin
            return 0;
        end
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $realtime, msg);
        error_count++;
    endtask

    task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input letter_t val);
        case (idx)
            CFG_KEY_R0C0:  key_copy[0] = val;
            CFG_KEY_R0C1:  key_copy[1] = val;
            CFG_KEY_R1C0:  key_copy[2] = val;
            CFG_KEY_R1C1:  key_copy[3] = val;
            CFG_DIRECTION: dir_copy = val[0];
            default:       ;
        endcase
    endtask

    // Hold the first letter of a pair; on the second, push both cipher letters
    task automatic encipher_letter(input letter_t raw);
        int          x, p, a, b, c, d, det, inv, i;
        int          m00, m01, m10, m11;
        logic        err;
        cipher_out_t r;
        x = int'(raw) % 26;
        if (!held_copy_valid)
        begin
            held_copy = letter_t'(x);
            held_copy_valid = 1'b1;
            return;
        end
        held_copy_valid = 1'b0;
        p = int'(held_copy);
        a = int'(key_copy[0]) % 26;
        b = int'(key_copy[1]) % 26;
        c = int'(key_copy[2]) % 26;
        d = int'(key_copy[3]) % 26;
        err = 1'b0;
        m00 = a;
        m01 = b;
        m10 = c;
        m11 = d;
        if (dir_copy == DirDecrypt)
        begin
            det = (a * d - b * c) % 26;
            if (det < 0)
            begin
                det = det + 26;
            end
            inv = 0;
            for (i = 1; i < 26; i++)
            begin
                if ((det * i) % 26 == 1)
                begin
                    inv = i;
                end
            end
            err = (inv == 0);
            m00 = (d * inv) % 26;
            m01 = ((26 - b) * inv) % 26;
            m10 = ((26 - c) * inv) % 26;
            m11 = (a * inv) % 26;
        end
        if (err)
        begin
            singular_pairs++;
        end
        r.letter_out = err ? letter_t'(0) : letter_t'((m00 * p + m01 * x) % 26);
        r.pair_end   = 1'b0;
        r.key_error  = err;
        expected_letters.push_back(r);
        r.letter_out = err ? letter_t'(0) : letter_t'((m10 * p + m11 * x) % 26);
        r.pair_end   = 1'b1;
        expected_letters.push_back(r);
    endtask

    // Letter driver: advance only when the current transaction has gone
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_valid <= 1'b0;
            letter_in    <= '0;
            send_gap     <= 0;
        end
        else if (!letter_valid || !letter_stall)
        begin
            if (send_gap > 0)
            begin
                letter_valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (letter_queue.size() > 0)
            begin
                letter_valid <= 1'b1;
                letter_in    <= letter_queue.pop_front();
                send_gap     <= idle_length(send_idle_pct);
            end
            else
            begin
                letter_valid <= 1'b0;
            end
        end
    end

    // Result receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            stall_draw = idle_length(recv_idle_pct);
            result_stall <= (stall_draw > 0);
            hold_left    <= (stall_draw > 0) ? stall_draw - 1 : 0;
        end
    end

    // Monitor: track register writes, predict on accepted letters, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
            end
            if (letter_valid && !letter_stall)
            begin
                encipher_letter(letter_in);
                letters_accepted++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_letters.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result letter_out=%0d pair_end=%0b",
                                              letter_out, pair_end));
                end
                else
                begin
                    if (letter_out !== expected_letters[0].letter_out)
                    begin
                        report_mismatch($sformatf("result %0d letter_out %0d, expected %0d",
                                                  results_checked, letter_out,
                                                  expected_letters[0].letter_out));
                    end
                    if (pair_end !== expected_letters[0].pair_end)
                    begin
                        report_mismatch($sformatf("result %0d pair_end %b, expected %b",
                                                  results_checked, pair_end,
                                                  expected_letters[0].pair_end));
                    end
                    if (key_error !== expected_letters[0].key_error)
                    begin
                        report_mismatch($sformatf("result %0d key_error %b, expected %b",
                                                  results_checked, key_error,
                                                  expected_letters[0].key_error));
                    end
                    void'(expected_letters.pop_front());
                    results_checked++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input letter_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every pushed letter and every expected result, then let the back end drain
    task automatic settle();
        while (letters_accepted != letters_pushed || expected_letters.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic feed_directed(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            letter_queue.push_back(directed_letters[dir_pos]);
            dir_pos++;
            letters_pushed++;
        end
        settle();
    endtask

    function automatic letter_t pick_key();
        case ($urandom_range(19))
            0:       return letter_t'(0);
            1:       return letter_t'(25);
            2:       return letter_t'($urandom_range(31, 26));
            default: return letter_t'($urandom_range(25));
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 20;
            2:       return 50;
            default: return 80;
        endcase
    endfunction

    initial
    begin
        int random_sent;
        int phase_len;
        int phases;
        int n;
        key_copy[0]     = KeyR0C0Rst;
        key_copy[1]     = KeyR0C1Rst;
        key_copy[2]     = KeyR1C0Rst;
        key_copy[3]     = KeyR1C1Rst;
        dir_copy        = DirEncrypt;
        held_copy       = '0;
        held_copy_valid = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        random_sent     = 0;
        phases          = 6;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset key, encrypt: extreme and out-of-range letters
        feed_directed(6);
        // Reset key, decrypt; leave a letter held across the next write
        write_reg(CFG_DIRECTION, letter_t'(DirDecrypt));
        feed_directed(5);
        // Out-of-range key values complete the held pair
        write_reg(CFG_KEY_R0C0, 5'd31);
        write_reg(CFG_KEY_R0C1, 5'd26);
        write_reg(CFG_KEY_R1C0, 5'd26);
        write_reg(CFG_KEY_R1C1, 5'd31);
        send_idle_pct = 50;
        recv_idle_pct = 50;
        feed_directed(3);
        // Singular key while decrypting
        write_reg(CFG_KEY_R0C0, 5'd2);
        write_reg(CFG_KEY_R0C1, 5'd4);
        write_reg(CFG_KEY_R1C0, 5'd1);
        write_reg(CFG_KEY_R1C1, 5'd2);
        feed_directed(4);
        // Same singular key in encrypt mode: no error flag
        write_reg(CFG_DIRECTION, letter_t'(DirEncrypt));
        feed_directed(3);
        // All-zero key
        write_reg(CFG_KEY_R0C0, 5'd0);
        write_reg(CFG_KEY_R0C1, 5'd0);
        write_reg(CFG_KEY_R1C0, 5'd0);
        write_reg(CFG_KEY_R1C1, 5'd0);
        feed_directed(3);

        while (random_sent < RANDOM_ITEMS)
        begin
            send_idle_pct = pick_idle_pct();
            recv_idle_pct = pick_idle_pct();
            if ($urandom_range(9) < 7) write_reg(CFG_KEY_R0C0, pick_key());
            if ($urandom_range(9) < 7) write_reg(CFG_KEY_R0C1, pick_key());
            if ($urandom_range(9) < 7) write_reg(CFG_KEY_R1C0, pick_key());
            if ($urandom_range(9) < 7) write_reg(CFG_KEY_R1C1, pick_key());
            if ($urandom_range(9) < 6) write_reg(CFG_DIRECTION, letter_t'($urandom_range(1)));
            phase_len = ($urandom_range(7) == 0) ? $urandom_range(3, 1) : $urandom_range(60, 8);
            for (n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    letter_queue.push_back(letter_t'($urandom_range(31, 26)));
                end
                else
                begin
                    letter_queue.push_back(letter_t'($urandom_range(25)));
                end
                letters_pushed++;
            end
            random_sent += phase_len;
            phases++;
            settle();
        end

        $display("Fed %0d letters over %0d key/direction phases; compared %0d results,",
                 letters_pushed, phases, results_checked);
        $display("%0d of the pairs under a singular decrypt key; %0d mismatches.",
                 singular_pairs, error_count);
        if (error_count == 0)
        begin
            $display("hill_cipher_2x2_mod26_core verification clean");
        end
        else
        begin
            $display("hill_cipher_2x2_mod26_core verification failed");
        end
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, expected_letters.size());
        $display("hill_cipher_2x2_mod26_core verification failed");
        $finish;
    end

endmodule
